[design/cmbp_pkg.sv]
// shared constants, types and command/status structs of the bit predictor
`timescale 1ns / 1ps
package cmbp_pkg;

  localparam int unsigned DATA_DEPTH  = 1024;
  localparam int unsigned TABLE_DEPTH = 524288;
  localparam int unsigned MODEL_CNT   = 33;

  localparam int unsigned HIST_AW = $clog2(DATA_DEPTH);
  localparam int unsigned SPOS_W  = $clog2(DATA_DEPTH + 1);
  localparam int unsigned TAB_AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned PROBE_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MI_W    = $clog2(MODEL_CNT + 1);
  localparam bit          TAB_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  localparam logic [31:0] HASH_MUL0  = 32'd4112361;
  localparam logic [31:0] HASH_MUL   = 32'd237;
  localparam logic [31:0] HASH_ADD   = 32'd4123;
  localparam logic [15:0] SEEN_MASK  = 16'hFF00;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [23:0] WEIGHT_MAX = 24'hFFFFFF;
  localparam int unsigned ALWAYS_ON  = 32;

  localparam int unsigned ACC_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODEL_ENABLE = 2'd0,
    CFG_BOOST        = 2'd1,
    CFG_BASE_ONES    = 2'd2,
    CFG_BASE_ZEROS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              used;
    logic [31:0]       hash;
    logic [SPOS_W-1:0] pos1;   // byte position plus one, zero for the preroll byte
    logic [7:0]        model;
    logic [2:0]        bitpos;
    logic [15:0]       cnt1;
    logic [15:0]       cnt0;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic next_model;
    logic hash_init;
    logic hash_step;
    logic mod_init;
    logic mod_step;
    logic probe_start;
    logic probe_next;
    logic set_ovf;
    logic new_entry;
    logic ent_load;
    logic hist_read;
    logic ver_next;
    logic update;
    logic accum;
    logic bit_next;
    logic pre_done;
    logic emit;
    logic byte_end;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mi_done;
    logic model_on;
    logic hash_done;
    logic mod_done;
    logic probe_full;
    logic ent_used;
    logic key_match;
    logic ver_done;
    logic ver_need;
    logic ver_ok;
    logic pre_active;
    logic bit_last;
    logic out_full;
    logic byte_last;
  } sts_t;

endpackage

[design/cmbp_if.sv]
// valid/ready channel interfaces for data bytes and bit results
`timescale 1ns / 1ps
interface cmbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;
  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface cmbp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] ones_weight;
  logic [23:0] zeros_weight;
  logic        coded_bit;
  logic        last_of_byte;
  logic        table_overflow;
  modport source (output valid, output ones_weight, output zeros_weight, output coded_bit,
                  output last_of_byte, output table_overflow, input ready);
  modport sink (input valid, input ones_weight, input zeros_weight, input coded_bit,
                input last_of_byte, input table_overflow, output ready);
endinterface

[design/context_model_bit_predictor.sv]
// top level of the context-mixing bit-count predictor
`timescale 1ns / 1ps
// usage:
//   in_i takes one data byte per transaction (data_byte, end_of_data). for every byte the
//   block returns eight transactions on out_o, top bit first, each with the summed ones and
//   zeros weights, the bit itself, a last-of-byte mark on the eighth and a table overflow flag.
//   cfg_we_i/cfg_index_i/cfg_data_i write the model enables, the boost, the ones base and
//   the zeros base; write them only while the block is idle.
// operation:
//   one byte at a time. each bit runs every enabled model through a shared sequencer:
//   it picks the model (skipping a disabled one), hashes one step per bit of the selector,
//   reduces the hash to a table index (by a bit-serial remainder when TABLE_DEPTH is not a
//   power of two) and probes the table; an empty slot takes a new entry, while a hit reads
//   the history to verify the current byte and each selected byte up to 8 back, then closes
//   with the count update. the single table port and the history port set the pace. the
//   first byte after reset or after the byte that ends the data or fills the history also
//   runs a silent zero byte first.
// reset and clearing:
//   after reset, and after the byte that ends the data or fills the history, the table is
//   swept empty one entry a cycle with in_i.ready low; config writes are still taken.
// stalls:
//   results sit in an output register; a stalled receiver holds the sequencer only at the end
//   of the next bit, and a new byte is taken while the last result still waits.
module context_model_bit_predictor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cmbp_in_if.sink                             in_i,
  cmbp_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [cmbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cmbp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cmbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the state machine and the input handshake
  cmbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: memories, hash, counters and result register
  cmbp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .data_byte_i      (in_i.data_byte),
    .end_of_data_i    (in_i.end_of_data),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .ones_weight_o    (out_o.ones_weight),
    .zeros_weight_o   (out_o.zeros_weight),
    .coded_bit_o      (out_o.coded_bit),
    .last_of_byte_o   (out_o.last_of_byte),
    .table_overflow_o (out_o.table_overflow)
  );

  // a byte transaction keeps the block busy for at least the following cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after a byte transaction");

  // a result is never loaded over one that the receiver has not taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sts.out_full)
    else $error("result register overwritten");

  // no byte is taken while the table sweep runs
  a_clear_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_step |-> !in_i.ready)
    else $error("input ready during table clear");

endmodule

[design/cmbp_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
module cmbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

[design/cmbp_ctrl.sv]
// sequencer of the bit predictor: clear pass, hashing, probing, verify, update
`timescale 1ns / 1ps
module cmbp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cmbp_pkg::sts_t sts_i,
  output cmbp_pkg::cmd_t cmd_o
);
  import cmbp_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_MODEL = 12'b000000000100,
    S_HASH  = 12'b000000001000,
    S_MOD   = 12'b000000010000,
    S_PROBE = 12'b000000100000,
    S_PCHK  = 12'b000001000000,
    S_VRD   = 12'b000010000000,
    S_VCHK  = 12'b000100000000,
    S_UPD   = 12'b001000000000,
    S_ACC   = 12'b010000000000,
    S_BIT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MODEL;
        end
      end
      S_MODEL: begin
        if (sts_i.mi_done) begin
          state_d = S_BIT;
        end else if (sts_i.model_on) begin
          cmd_o.hash_init = 1'b1;
          state_d         = S_HASH;
        end else begin
          cmd_o.next_model = 1'b1;
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.mod_init = 1'b1;
          state_d        = S_MOD;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.probe_start = 1'b1;
          state_d           = S_PROBE;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (sts_i.probe_full) begin
          cmd_o.set_ovf    = 1'b1;
          cmd_o.next_model = 1'b1;
          state_d          = S_MODEL;
        end else begin
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (!sts_i.ent_used) begin
          cmd_o.new_entry  = 1'b1;
          cmd_o.next_model = 1'b1;
          state_d          = S_MODEL;
        end else if (sts_i.key_match) begin
          cmd_o.ent_load = 1'b1;
          state_d        = S_VRD;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_PROBE;
        end
      end
      S_VRD: begin
        if (sts_i.ver_done) begin
          state_d = S_UPD;
        end else if (sts_i.ver_need) begin
          cmd_o.hist_read = 1'b1;
          state_d         = S_VCHK;
        end else begin
          cmd_o.ver_next = 1'b1;
        end
      end
      S_VCHK: begin
        if (sts_i.ver_ok) begin
          cmd_o.ver_next = 1'b1;
          state_d        = S_VRD;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_PROBE;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.accum      = 1'b1;
        cmd_o.next_model = 1'b1;
        state_d          = S_MODEL;
      end
      S_BIT: begin
        if (sts_i.pre_active) begin
          cmd_o.bit_next = 1'b1;
          cmd_o.pre_done = sts_i.bit_last;
          state_d        = S_MODEL;
        end else if (!sts_i.out_full) begin
          cmd_o.emit = 1'b1;
          if (sts_i.bit_last) begin
            cmd_o.byte_end = 1'b1;
            state_d        = sts_i.byte_last ? S_CLEAR : S_IDLE;
          end else begin
            cmd_o.bit_next = 1'b1;
            state_d        = S_MODEL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule

[design/cmbp_dp.sv]
// datapath: history, context table, hash and remainder units, weight sums
`timescale 1ns / 1ps
module cmbp_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmbp_pkg::cmd_t                     cmd_i,
  output cmbp_pkg::sts_t                     sts_o,
  input  logic                               cfg_we_i,
  input  logic [cmbp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cmbp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [7:0]                         data_byte_i,
  input  logic                               end_of_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [23:0]                        ones_weight_o,
  output logic [23:0]                        zeros_weight_o,
  output logic                               coded_bit_o,
  output logic                               last_of_byte_o,
  output logic                               table_overflow_o
);
  import cmbp_pkg::*;

  // configuration
  logic [31:0] model_enable_q;
  logic [7:0]  boost_q, base_ones_q, base_zeros_q;

  // byte and position state
  logic [HIST_AW-1:0] pos_q;
  logic               preroll_q, pre_q, eod_q;
  logic [7:0]         data_q;
  logic [7:0]         prev_q [8];

  // per-lookup state
  logic [2:0]         bit_q;
  logic [MI_W-1:0]    mi_q;
  logic [31:0]        h_q, hs_q;
  logic [7:0]         m_q;
  logic [3:0]         k_q;
  logic [5:0]         mcnt_q;
  logic [TAB_AW-1:0]  rem_q, idx_q, clr_q;
  logic [PROBE_W-1:0] probe_q;
  entry_t             ent_q;
  logic               hz_q;
  logic [23:0]        ps_q, po_q;
  logic [ACC_W-1:0]   acc1_q, acc0_q;
  logic               ovf_q;

  // memories
  logic [ENTRY_W-1:0] tab_rdata, tab_wdata;
  logic [TAB_AW-1:0]  tab_addr;
  logic               tab_we;
  logic [7:0]         hist_rdata;
  logic [HIST_AW-1:0] hist_addr;

  logic [7:0]          cur, mask8, model8, prev_k, hv;
  logic                cbit;
  entry_t              rd, new_ent, upd_ent;
  logic [SPOS_W-1:0]   pos1_cur;
  logic [SPOS_W:0]     vdiff;
  logic [15:0]         cs, co, ns, no;
  logic                boost_on;
  logic [TAB_AW:0]     mod_t;
  logic [ACC_W:0]      sum1, sum0;

  assign cur      = pre_q ? 8'd0 : data_q;
  assign mask8    = 8'(SEEN_MASK >> bit_q);
  assign model8   = 8'(mi_q) - 8'd1;
  assign prev_k   = prev_q[3'(k_q - 4'd1)];
  assign cbit     = cur[~bit_q];
  assign pos1_cur = pre_q ? '0 : SPOS_W'(pos_q) + SPOS_W'(1);
  assign rd       = entry_t'(tab_rdata);
  assign vdiff    = {1'b0, ent_q.pos1} - (SPOS_W + 1)'(k_q) - (SPOS_W + 1)'(1);
  assign hv       = hz_q ? 8'd0 : hist_rdata;
  assign mod_t    = {rem_q, hs_q[31]};

  assign cs       = cbit ? ent_q.cnt1 : ent_q.cnt0;
  assign co       = cbit ? ent_q.cnt0 : ent_q.cnt1;
  assign ns       = (cs == COUNT_MAX) ? cs : cs + 16'd1;
  assign no       = 16'(({1'b0, co} + 17'd1) >> 1);
  assign boost_on = (cs == 16'd0) || (co == 16'd0);

  always_comb begin
    new_ent        = '0;
    new_ent.used   = 1'b1;
    new_ent.hash   = h_q;
    new_ent.pos1   = pos1_cur;
    new_ent.model  = model8;
    new_ent.bitpos = bit_q;
    new_ent.cnt1   = cbit ? 16'd1 : 16'd0;
    new_ent.cnt0   = cbit ? 16'd0 : 16'd1;
    upd_ent        = ent_q;
    upd_ent.cnt1   = cbit ? ns : no;
    upd_ent.cnt0   = cbit ? no : ns;
  end

  assign tab_addr  = cmd_i.clear_step ? clr_q : idx_q;
  assign tab_we    = cmd_i.clear_step | cmd_i.new_entry | cmd_i.update;
  assign tab_wdata = cmd_i.clear_step ? '0 : (cmd_i.new_entry ? new_ent : upd_ent);
  assign hist_addr = cmd_i.accept ? pos_q : vdiff[HIST_AW-1:0];

  cmbp_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .addr_i  (tab_addr),
    .wdata_i (tab_wdata),
    .rdata_o (tab_rdata)
  );

  cmbp_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .addr_i  (hist_addr),
    .wdata_i (data_byte_i),
    .rdata_o (hist_rdata)
  );

  // status
  assign sum1 = {1'b0, acc1_q} + (ACC_W + 1)'(base_ones_q);
  assign sum0 = {1'b0, acc0_q} + (ACC_W + 1)'(base_zeros_q);

  always_comb begin
    sts_o            = '0;
    sts_o.clear_last = (clr_q == TAB_AW'(TABLE_DEPTH - 1));
    sts_o.mi_done    = (mi_q == MI_W'(MODEL_CNT));
    sts_o.model_on   = (32'(mi_q) == 32'(ALWAYS_ON)) ||
                       ((32'(mi_q) < 32'd32) && model_enable_q[5'(mi_q)]);
    sts_o.hash_done  = (m_q == 8'd0);
    sts_o.mod_done   = (mcnt_q == 6'd32);
    sts_o.probe_full = (probe_q == PROBE_W'(TABLE_DEPTH));
    sts_o.ent_used   = rd.used;
    sts_o.key_match  = (rd.hash == h_q) && (rd.bitpos == bit_q) && (rd.model == model8);
    sts_o.ver_done   = (k_q == 4'd9);
    sts_o.ver_need   = (k_q == 4'd0) || ent_q.model[3'(k_q - 4'd1)];
    sts_o.ver_ok     = (k_q == 4'd0) ? ((hv & mask8) == (cur & mask8)) : (hv == prev_k);
    sts_o.pre_active = pre_q;
    sts_o.bit_last   = (bit_q == 3'd7);
    sts_o.out_full   = out_valid_o && !out_ready_i;
    sts_o.byte_last  = eod_q || (pos_q == HIST_AW'(DATA_DEPTH - 1));
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_enable_q <= 32'hFFFFFFFF;
      boost_q        <= 8'd4;
      base_ones_q    <= 8'd4;
      base_zeros_q   <= 8'd4;
      pos_q          <= '0;
      preroll_q      <= 1'b1;
      pre_q          <= 1'b0;
      clr_q          <= '0;
      bit_q          <= '0;
      mi_q           <= '0;
      k_q            <= '0;
      mcnt_q         <= '0;
      probe_q        <= '0;
      out_valid_o    <= 1'b0;
      for (int i = 0; i < 8; i++) prev_q[i] <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODEL_ENABLE: model_enable_q <= cfg_data_i;
          CFG_BOOST:        boost_q        <= cfg_data_i[7:0];
          CFG_BASE_ONES:    base_ones_q    <= cfg_data_i[7:0];
          CFG_BASE_ZEROS:   base_zeros_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_step) clr_q <= clr_q + TAB_AW'(1);
      if (cmd_i.accept) begin
        pre_q <= preroll_q;
        bit_q <= '0;
        mi_q  <= '0;
      end
      if (cmd_i.next_model) mi_q <= mi_q + MI_W'(1);
      if (cmd_i.hash_init) k_q <= 4'd1;
      if (cmd_i.hash_step) k_q <= k_q + 4'd1;
      if (cmd_i.mod_init) mcnt_q <= TAB_POW2 ? 6'd32 : 6'd0;
      if (cmd_i.mod_step) mcnt_q <= mcnt_q + 6'd1;
      if (cmd_i.probe_start) probe_q <= '0;
      if (cmd_i.probe_next) probe_q <= probe_q + PROBE_W'(1);
      if (cmd_i.ent_load) k_q <= 4'd0;
      if (cmd_i.ver_next) k_q <= k_q + 4'd1;
      if (cmd_i.bit_next) begin
        bit_q <= bit_q + 3'd1;
        mi_q  <= '0;
      end
      if (cmd_i.pre_done) begin
        pre_q     <= 1'b0;
        preroll_q <= 1'b0;
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.emit) out_valid_o <= 1'b1;
      if (cmd_i.byte_end) begin
        if (sts_o.byte_last) begin
          pos_q     <= '0;
          preroll_q <= 1'b1;
          clr_q     <= '0;
          for (int i = 0; i < 8; i++) prev_q[i] <= 8'd0;
        end else begin
          pos_q     <= pos_q + HIST_AW'(1);
          prev_q[0] <= cur;
          for (int i = 1; i < 8; i++) prev_q[i] <= prev_q[i-1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q <= data_byte_i;
      eod_q  <= end_of_data_i;
    end
    if (cmd_i.accept || cmd_i.bit_next) begin
      acc1_q <= '0;
      acc0_q <= '0;
      ovf_q  <= 1'b0;
    end
    if (cmd_i.hash_init) begin
      h_q <= 32'({21'd0, cur & mask8, bit_q} * HASH_MUL0);
      m_q <= model8;
    end
    if (cmd_i.hash_step) begin
      h_q <= 32'(h_q * HASH_MUL) + HASH_ADD + (m_q[0] ? {24'd0, prev_k} : 32'd0);
      m_q <= m_q >> 1;
    end
    if (cmd_i.mod_init) begin
      rem_q <= TAB_POW2 ? h_q[TAB_AW-1:0] : '0;
      hs_q  <= h_q;
    end
    if (cmd_i.mod_step) begin
      // restoring remainder, one bit of the hash a step
      rem_q <= (mod_t >= (TAB_AW + 1)'(TABLE_DEPTH)) ?
               TAB_AW'(mod_t - (TAB_AW + 1)'(TABLE_DEPTH)) : TAB_AW'(mod_t);
      hs_q  <= hs_q << 1;
    end
    if (cmd_i.probe_start) idx_q <= rem_q;
    if (cmd_i.probe_next) begin
      idx_q <= (idx_q == TAB_AW'(TABLE_DEPTH - 1)) ? '0 : idx_q + TAB_AW'(1);
    end
    if (cmd_i.set_ovf) ovf_q <= 1'b1;
    if (cmd_i.ent_load) ent_q <= rd;
    if (cmd_i.hist_read) hz_q <= vdiff[SPOS_W];
    if (cmd_i.update) begin
      ps_q <= boost_on ? 24'(cs) * 24'(boost_q) : 24'(cs);
      po_q <= boost_on ? 24'(co) * 24'(boost_q) : 24'(co);
    end
    if (cmd_i.accum) begin
      acc1_q <= acc1_q + ACC_W'(cbit ? ps_q : po_q);
      acc0_q <= acc0_q + ACC_W'(cbit ? po_q : ps_q);
    end
    if (cmd_i.emit) begin
      ones_weight_o    <= (sum1 > (ACC_W + 1)'(WEIGHT_MAX)) ? WEIGHT_MAX : sum1[23:0];
      zeros_weight_o   <= (sum0 > (ACC_W + 1)'(WEIGHT_MAX)) ? WEIGHT_MAX : sum0[23:0];
      coded_bit_o      <= cbit;
      last_of_byte_o   <= (bit_q == 3'd7);
      table_overflow_o <= ovf_q;
    end
  end
endmodule
